// File: design/hslc_pkg.sv
// Shared types and constants for the HSL to RGB converter.
// No dependencies; used by hslc_ramp and hsl_to_rgb_converter.
package hslc_pkg;

  // Default fraction width of saturation, lightness and the color outputs
  localparam int unsigned FRAC_BITS_DEF = 8;

  // Hue is counted in 1/1536 of a turn
  localparam int unsigned HUE_W = 11;
  localparam logic [HUE_W-1:0] HUE_TURN   = HUE_W'(1536);
  localparam logic [HUE_W-1:0] HUE_THIRD  = HUE_W'(512);
  localparam logic [HUE_W-1:0] HUE_SIXTH  = HUE_W'(256);
  localparam logic [HUE_W-1:0] HUE_HALF   = HUE_W'(768);
  localparam logic [HUE_W-1:0] HUE_2THIRD = HUE_W'(1024);

  // Ramp slope factor runs 0..256, and the ramp product drops 8 bits
  localparam int unsigned FACT_W     = 9;
  localparam int unsigned RAMP_SHIFT = 8;

  // Segment of the piecewise hue ramp
  typedef enum logic [1:0] {
    RG_RISE,
    RG_HIGH,
    RG_FALL,
    RG_LOW
  } hslc_region_e;

  // Stage advance enables handed to each channel
  typedef struct packed {
    logic en4;
    logic en5;
  } hslc_adv_t;

endpackage

// File: design/hslc_ramp.sv
// One color channel of the HSL to RGB converter: samples the hue ramp.
// Holds pipeline stages four and five; depends on hslc_pkg.
module hslc_ramp #(
  parameter int unsigned FRAC_BITS = hslc_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  hslc_pkg::hslc_adv_t               adv_i,
  input  logic [hslc_pkg::HUE_W-1:0]        pos_i,
  input  logic [FRAC_BITS:0]                p_i,
  input  logic [FRAC_BITS:0]                q_i,
  input  logic [FRAC_BITS:0]                d_i,
  output logic [FRAC_BITS:0]                color_o
);

  localparam int unsigned W    = FRAC_BITS + 1;
  localparam int unsigned PW   = W + hslc_pkg::FACT_W;
  localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

  hslc_pkg::hslc_region_e         region;
  logic [hslc_pkg::FACT_W-1:0]    factor;
  logic [hslc_pkg::HUE_W-1:0]     fall_pos;

  logic [PW-1:0]                  prod_d, prod_q;
  logic [W-1:0]                   p4_q, q4_q;
  hslc_pkg::hslc_region_e         rg4_q;

  logic [W:0]                     sum;
  logic [W:0]                     sel;
  logic [W-1:0]                   color_d, color_q;

  // Decode the ramp segment and its slope factor
  assign fall_pos = hslc_pkg::HUE_2THIRD - pos_i;

  always_comb begin
    if (pos_i < hslc_pkg::HUE_SIXTH) begin
      region = hslc_pkg::RG_RISE;
      factor = pos_i[hslc_pkg::FACT_W-1:0];
    end else if (pos_i < hslc_pkg::HUE_HALF) begin
      region = hslc_pkg::RG_HIGH;
      factor = '0;
    end else if (pos_i < hslc_pkg::HUE_2THIRD) begin
      region = hslc_pkg::RG_FALL;
      factor = fall_pos[hslc_pkg::FACT_W-1:0];
    end else begin
      region = hslc_pkg::RG_LOW;
      factor = '0;
    end
  end

  assign prod_d = PW'(d_i) * PW'(factor);

  // Stage four: slope product
  always_ff @(posedge clk_i) begin
    if (adv_i.en4) begin
      prod_q <= prod_d;
      p4_q   <= p_i;
      q4_q   <= q_i;
      rg4_q  <= region;
    end
  end

  // Pick the segment value and limit it to full scale
  assign sum = (W + 1)'(p4_q) + (W + 1)'(prod_q[hslc_pkg::RAMP_SHIFT +: W]);

  always_comb begin
    case (rg4_q)
      hslc_pkg::RG_RISE: sel = sum;
      hslc_pkg::RG_FALL: sel = sum;
      hslc_pkg::RG_HIGH: sel = (W + 1)'(q4_q);
      hslc_pkg::RG_LOW:  sel = (W + 1)'(p4_q);
      default:           sel = (W + 1)'(p4_q);
    endcase
  end

  assign color_d = (sel > (W + 1)'(ONE)) ? ONE : sel[W-1:0];

  // Stage five: output register
  always_ff @(posedge clk_i) begin
    if (adv_i.en5) begin
      color_q <= color_d;
    end
  end

  assign color_o = color_q;

endmodule

// File: design/hsl_to_rgb_converter.sv
// HSL to RGB color converter, top level.
// Depends on hslc_pkg and hslc_ramp (one instance per color channel).
//
// Converts one pixel per clock while not stalled from hue, saturation and
// lightness to red, green and blue. Saturation, lightness and the outputs
// carry FRAC_BITS fraction bits (full scale is 2^FRAC_BITS); hue counts
// 1/1536 of a turn, and a hue from 1536 up is taken modulo one turn. The
// pipeline is five register stages deep: input clamp, the lightness-
// saturation multiply, the q/p/ramp-position stage, the per-channel ramp
// multiply, and the output register. A new transaction is taken every
// cycle unless the input is stalled; a stall at the output backs up only
// as far as the pipeline is full, so bubbles are squeezed out. Zero
// saturation falls out of the arithmetic as grey equal to lightness.
module hsl_to_rgb_converter #(
  parameter int unsigned FRAC_BITS = hslc_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [hslc_pkg::HUE_W-1:0] hue_i,
  input  logic [FRAC_BITS:0]         saturation_i,
  input  logic [FRAC_BITS:0]         lightness_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [FRAC_BITS:0]         red_o,
  output logic [FRAC_BITS:0]         green_o,
  output logic [FRAC_BITS:0]         blue_o
);

  localparam int unsigned W     = FRAC_BITS + 1;
  localparam int unsigned HW    = hslc_pkg::HUE_W;
  localparam logic [W-1:0] ONE  = W'(1) << FRAC_BITS;
  localparam logic [W-1:0] HALF = ONE >> 1;

  // Stage valids and advance enables
  logic [5:1] v_q;
  logic [5:1] adv;
  hslc_pkg::hslc_adv_t adv_ch;

  // Stage one
  logic [HW-1:0] h1_d, h1_q;
  logic [W-1:0]  s1_d, s1_q, l1_d, l1_q;
  // Stage two
  logic [2*W-1:0] ls_prod;
  logic [HW-1:0]  h2_q;
  logic [W-1:0]   s2_q, l2_q, m2_q;
  // Stage three
  logic [W:0]     q_wide, p_wide;
  logic [W-1:0]   q3_d, p3_d;
  logic [HW-1:0]  pr_sum, pr_d, pb_d;
  logic [W-1:0]   p3_q, q3_q, d3_q;
  logic [HW-1:0]  pr3_q, pg3_q, pb3_q;

  // Advance a stage when it is empty or its successor moves
  assign adv[5] = !v_q[5] || !out_stall_i;
  assign adv[4] = !v_q[4] || adv[5];
  assign adv[3] = !v_q[3] || adv[4];
  assign adv[2] = !v_q[2] || adv[3];
  assign adv[1] = !v_q[1] || adv[2];

  assign in_stall_o  = !adv[1];
  assign out_valid_o = v_q[5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[1]) v_q[1] <= in_valid_i;
      if (adv[2]) v_q[2] <= v_q[1];
      if (adv[3]) v_q[3] <= v_q[2];
      if (adv[4]) v_q[4] <= v_q[3];
      if (adv[5]) v_q[5] <= v_q[4];
    end
  end

  // Stage one: wrap hue once and limit saturation and lightness
  assign h1_d = (hue_i >= hslc_pkg::HUE_TURN) ? (hue_i - hslc_pkg::HUE_TURN) : hue_i;
  assign s1_d = (saturation_i > ONE) ? ONE : saturation_i;
  assign l1_d = (lightness_i > ONE) ? ONE : lightness_i;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      h1_q <= h1_d;
      s1_q <= s1_d;
      l1_q <= l1_d;
    end
  end

  // Stage two: l*s scaled back to the fraction width
  assign ls_prod = (2 * W)'(l1_q) * (2 * W)'(s1_q);

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      h2_q <= h1_q;
      s2_q <= s1_q;
      l2_q <= l1_q;
      m2_q <= ls_prod[FRAC_BITS +: W];
    end
  end

  // Stage three: q, p and the three ramp positions
  always_comb begin
    if (l2_q < HALF) begin
      q_wide = (W + 1)'(l2_q) + (W + 1)'(m2_q);
    end else begin
      q_wide = (W + 1)'(l2_q) + (W + 1)'(s2_q) - (W + 1)'(m2_q);
    end
  end

  assign q3_d   = q_wide[W-1:0];
  assign p_wide = ((W + 1)'(l2_q) << 1) - (W + 1)'(q3_d);
  assign p3_d   = p_wide[W-1:0];

  assign pr_sum = h2_q + hslc_pkg::HUE_THIRD;
  assign pr_d   = (pr_sum > hslc_pkg::HUE_TURN) ? (pr_sum - hslc_pkg::HUE_TURN) : pr_sum;
  assign pb_d   = (h2_q < hslc_pkg::HUE_THIRD) ? (h2_q + hslc_pkg::HUE_2THIRD)
                                               : (h2_q - hslc_pkg::HUE_THIRD);

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      p3_q  <= p3_d;
      q3_q  <= q3_d;
      d3_q  <= q3_d - p3_d;
      pr3_q <= pr_d;
      pg3_q <= h2_q;
      pb3_q <= pb_d;
    end
  end

  // Stages four and five: one ramp per channel
  assign adv_ch.en4 = adv[4];
  assign adv_ch.en5 = adv[5];

  hslc_ramp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_red (
    .clk_i  (clk_i),
    .adv_i  (adv_ch),
    .pos_i  (pr3_q),
    .p_i    (p3_q),
    .q_i    (q3_q),
    .d_i    (d3_q),
    .color_o(red_o)
  );

  hslc_ramp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_green (
    .clk_i  (clk_i),
    .adv_i  (adv_ch),
    .pos_i  (pg3_q),
    .p_i    (p3_q),
    .q_i    (q3_q),
    .d_i    (d3_q),
    .color_o(green_o)
  );

  hslc_ramp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_blue (
    .clk_i  (clk_i),
    .adv_i  (adv_ch),
    .pos_i  (pb3_q),
    .p_i    (p3_q),
    .q_i    (q3_q),
    .d_i    (d3_q),
    .color_o(blue_o)
  );

  // Checks on the datapath and the stall chain
  a_pq_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] |-> (p3_q <= q3_q) && (q3_q <= ONE))
    else $error("p above q or q above full scale");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] |-> (pr3_q <= hslc_pkg::HUE_TURN) && (pg3_q < hslc_pkg::HUE_TURN)
               && (pb3_q < hslc_pkg::HUE_TURN))
    else $error("ramp position out of range");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (red_o <= ONE) && (green_o <= ONE) && (blue_o <= ONE))
    else $error("color above full scale");

  a_no_stall_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v_q == 5'b11111) && out_stall_i)
    else $error("input stalled with room in the pipeline");

endmodule
